### rtl/i2cm_pkg.sv
// Shared types, status codes and action codes for the I2C master register transfer unit.
`default_nettype none
package i2cm_pkg;

   // Transfer length cap and write buffer geometry
   localparam int unsigned MAX_LEN   = 256;
   localparam int unsigned LEN_W     = 9;
   localparam int unsigned BUF_DEPTH = 256;
   localparam int unsigned BUF_AW    = $clog2(BUF_DEPTH);
   localparam logic [LEN_W-1:0] LEN_CAP =
      LEN_W'((MAX_LEN > ((1 << LEN_W) - 1)) ? ((1 << LEN_W) - 1) : MAX_LEN);

   // Item operations
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_EVENT = 2'd2;

   // Controller status codes
   localparam logic [7:0] ST_START     = 8'h08;
   localparam logic [7:0] ST_RESTART   = 8'h10;
   localparam logic [7:0] ST_ADDR_ACK  = 8'h18;
   localparam logic [7:0] ST_DATA_ACK  = 8'h28;
   localparam logic [7:0] ST_ARB_LOST  = 8'h38;
   localparam logic [7:0] ST_RADDR_ACK = 8'h40;
   localparam logic [7:0] ST_RX_ACK    = 8'h50;
   localparam logic [7:0] ST_RX_NACK   = 8'h58;
   localparam logic [7:0] WRITE_MASK   = 8'hFE;

   // START and acknowledge control actions
   localparam logic [1:0] CTL_NONE  = 2'd0;
   localparam logic [1:0] CTL_SET   = 2'd1;
   localparam logic [1:0] CTL_CLEAR = 2'd2;

   // Completion codes
   localparam logic [1:0] DONE_BUSY  = 2'd0;
   localparam logic [1:0] DONE_READ  = 2'd1;
   localparam logic [1:0] DONE_WRITE = 2'd2;

   typedef struct packed {
      logic [1:0]       op;
      logic [7:0]       target_byte;
      logic [7:0]       first_register;
      logic [LEN_W-1:0] length;
      logic [7:0]       load_index;
      logic [7:0]       load_data;
      logic [7:0]       status_code;
      logic [7:0]       bus_data_in;
   } req_type;

   typedef struct packed {
      logic       data_out_valid;
      logic [7:0] data_out;
      logic [1:0] start_action;
      logic       stop_set;
      logic [1:0] ack_action;
      logic       clear_si;
      logic       rx_valid;
      logic [7:0] rx_index;
      logic [7:0] rx_byte;
      logic [1:0] done_res;
      logic       error_flag;
      logic [7:0] error_status;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [BUF_AW-1:0] addr;
      logic [7:0]        data;
   } wbuf_wr_type;

endpackage
`default_nettype wire

### rtl/i2cm_wbuf.sv
// Write byte buffer: one write port, one registered read port with write bypass.
`default_nettype none
module i2cm_wbuf (
   input  logic                         clock,
   input  i2cm_pkg::wbuf_wr_type        wr,
   input  logic [i2cm_pkg::BUF_AW-1:0]  rd_addr,
   output logic [7:0]                   rd_data
);
   import i2cm_pkg::*;

   logic [7:0] mem [BUF_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Forward a same-cycle write so the read reflects the updated entry
   always_ff @(posedge clock) begin
      if (wr.en && (wr.addr == rd_addr)) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/i2c_master_register_transfer_fsm_unit.sv
// Top level of the I2C master register transfer sequencer.
`default_nettype none
// Sequences an I2C master register transfer from controller status codes. A start
// item latches target byte, first register and length (capped at MAX_LEN); load
// items fill the 256-byte write buffer; each status event item returns one action
// set. Every item yields exactly one result. One item is taken per clock unless a
// stalled result holds the input register; an item passes through the input
// register, then the result register. The next write byte is kept prefetched by the
// buffer's registered read port at the byte pointer, so a data-ACK event needs no buffer read wait.
module i2c_master_register_transfer_fsm_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  i2cm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output i2cm_pkg::rsp_type rsp_data
);
   import i2cm_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   req_type           s1_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [7:0]        target_ff, target_in;
   logic [7:0]        first_reg_ff, first_reg_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [LEN_W-1:0]  rem_dec;
   logic [BUF_AW-1:0] bp_ff, bp_in;
   logic [7:0]        buf_rd;
   wbuf_wr_type       wr;
   logic [1:0]        mode_done;
   logic              advance;
   logic              fire;
   logic              req_accept;

   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign fire       = s1_valid_ff && advance;
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   i2cm_wbuf u_wbuf (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (bp_in),
      .rd_data (buf_rd)
   );

   always_comb begin
      s1_valid_in  = req_accept ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
      rsp_valid_in = fire ? 1'b1 : ((rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff);
   end

   always_comb begin
      rsp_in       = '0;
      target_in    = target_ff;
      first_reg_in = first_reg_ff;
      rem_in       = rem_ff;
      bp_in        = bp_ff;
      wr           = '0;
      rem_dec      = (rem_ff != '0) ? rem_ff - LEN_W'(1) : '0;
      mode_done    = target_ff[0] ? DONE_READ : DONE_WRITE;
      if (fire) begin
         unique case (s1_ff.op)
            OP_START: begin
               target_in           = s1_ff.target_byte;
               first_reg_in        = s1_ff.first_register;
               rem_in              = (s1_ff.length > LEN_CAP) ? LEN_CAP : s1_ff.length;
               bp_in               = '0;
               rsp_in.start_action = CTL_SET;
            end
            OP_LOAD: begin
               wr.en   = 1'b1;
               wr.addr = s1_ff.load_index[BUF_AW-1:0];
               wr.data = s1_ff.load_data;
            end
            OP_EVENT: begin
               unique case (s1_ff.status_code)
                  ST_START: begin
                     rsp_in.data_out_valid = 1'b1;
                     rsp_in.data_out       = target_ff & WRITE_MASK;
                     rsp_in.clear_si       = 1'b1;
                  end
                  ST_RESTART: begin
                     rsp_in.data_out_valid = 1'b1;
                     rsp_in.data_out       = target_ff | 8'h01;
                     rsp_in.clear_si       = 1'b1;
                  end
                  ST_ADDR_ACK: begin
                     rsp_in.start_action = CTL_CLEAR;
                     rsp_in.clear_si     = 1'b1;
                     if (rem_ff == '0) begin
                        rsp_in.stop_set = 1'b1;
                        rsp_in.done_res = mode_done;
                     end else begin
                        rsp_in.data_out_valid = 1'b1;
                        rsp_in.data_out       = first_reg_ff;
                     end
                  end
                  ST_DATA_ACK: begin
                     rsp_in.clear_si = 1'b1;
                     if (target_ff[0]) begin
                        // Register index sent: repeated start for the read phase
                        rsp_in.start_action = CTL_SET;
                     end else if (rem_ff == '0) begin
                        rsp_in.start_action = CTL_CLEAR;
                        rsp_in.stop_set     = 1'b1;
                        rsp_in.done_res     = mode_done;
                     end else begin
                        rsp_in.data_out_valid = 1'b1;
                        rsp_in.data_out       = buf_rd;
                        bp_in                 = bp_ff + BUF_AW'(1);
                        rem_in                = rem_dec;
                     end
                  end
                  ST_RADDR_ACK: begin
                     rsp_in.start_action = CTL_CLEAR;
                     rsp_in.ack_action   = (rem_ff > LEN_W'(1)) ? CTL_SET : CTL_CLEAR;
                     rsp_in.clear_si     = 1'b1;
                  end
                  ST_RX_ACK: begin
                     rsp_in.rx_valid   = 1'b1;
                     rsp_in.rx_index   = 8'(bp_ff);
                     rsp_in.rx_byte    = s1_ff.bus_data_in;
                     bp_in             = bp_ff + BUF_AW'(1);
                     rem_in            = rem_dec;
                     // NACK the byte that follows if it is the last one
                     rsp_in.ack_action = (rem_dec == LEN_W'(1)) ? CTL_CLEAR : CTL_SET;
                     rsp_in.clear_si   = 1'b1;
                  end
                  ST_RX_NACK: begin
                     rsp_in.rx_valid     = 1'b1;
                     rsp_in.rx_index     = 8'(bp_ff);
                     rsp_in.rx_byte      = s1_ff.bus_data_in;
                     rsp_in.start_action = CTL_CLEAR;
                     rsp_in.stop_set     = 1'b1;
                     rsp_in.clear_si     = 1'b1;
                     rsp_in.done_res     = mode_done;
                  end
                  ST_ARB_LOST: begin
                     // Bus is lost: no STOP, leave SI alone
                     rsp_in.done_res     = mode_done;
                     rsp_in.error_flag   = 1'b1;
                     rsp_in.error_status = s1_ff.status_code;
                  end
                  default: begin
                     rsp_in.error_flag   = 1'b1;
                     rsp_in.error_status = s1_ff.status_code;
                     rsp_in.start_action = CTL_CLEAR;
                     rsp_in.stop_set     = 1'b1;
                     rsp_in.clear_si     = 1'b1;
                     rsp_in.done_res     = mode_done;
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= '0;
         first_reg_ff <= '0;
         rem_ff       <= '0;
         bp_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         target_ff    <= target_in;
         first_reg_ff <= first_reg_in;
         rem_ff       <= rem_in;
         bp_ff        <= bp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   a_hold_stalled_item: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !fire) |=> s1_valid_ff)
      else $error("input stage dropped an item it had not processed");

   a_rem_capped: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= LEN_CAP)
      else $error("remaining count above length cap");

   a_stop_clears_si: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.stop_set) |-> rsp_data.clear_si)
      else $error("STOP requested without SI clear");

   a_rx_no_tx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.rx_valid) |-> !rsp_data.data_out_valid)
      else $error("received byte and transmit byte in one result");
`endif

endmodule
`default_nettype wire

### sim/i2c_master_register_transfer_fsm_checker.sv
// Checker for the I2C master register transfer unit: predicts each action set and compares.
`timescale 1ns / 100ps
module i2c_master_register_transfer_fsm_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  i2cm_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  i2cm_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending,
   output int                checked_count,
   output int                done_count
);
   import i2cm_pkg::*;

   // Sequencer state as the unit should hold it
   logic [7:0]       tgt;
   logic [7:0]       reg_idx;
   logic [LEN_W-1:0] remain;
   logic [7:0]       ptr;
   logic [7:0]       wbuf [BUF_DEPTH];

   rsp_type expected_actions[$];
   rsp_type want;

   function automatic rsp_type stop_and_finish(input rsp_type a);
      a.start_action = CTL_CLEAR;
      a.stop_set     = 1'b1;
      a.clear_si     = 1'b1;
      a.done_res     = tgt[0] ? DONE_READ : DONE_WRITE;
      return a;
   endfunction

   function automatic rsp_type next_actions(input req_type r);
      rsp_type a;
      a = '0;
      case (r.op)
         OP_START: begin
            tgt          = r.target_byte;
            reg_idx      = r.first_register;
            remain       = (r.length > LEN_CAP) ? LEN_CAP : r.length;
            ptr          = '0;
            a.start_action = CTL_SET;
         end
         OP_LOAD: wbuf[r.load_index] = r.load_data;
         OP_EVENT: begin
            case (r.status_code)
               ST_START: begin
                  a.data_out_valid = 1'b1;
                  a.data_out       = tgt & WRITE_MASK;
                  a.clear_si       = 1'b1;
               end
               ST_RESTART: begin
                  a.data_out_valid = 1'b1;
                  a.data_out       = tgt | 8'h01;
                  a.clear_si       = 1'b1;
               end
               ST_ADDR_ACK: begin
                  a.start_action = CTL_CLEAR;
                  if (remain == 0) begin
                     a = stop_and_finish(a);
                  end else begin
                     a.data_out_valid = 1'b1;
                     a.data_out       = reg_idx;
                     a.clear_si       = 1'b1;
                  end
               end
               ST_DATA_ACK: begin
                  // a read turns around with a repeated START after the register index
                  if (tgt[0]) begin
                     a.start_action = CTL_SET;
                     a.clear_si     = 1'b1;
                  end else if (remain == 0) begin
                     a = stop_and_finish(a);
                  end else begin
                     a.data_out_valid = 1'b1;
                     a.data_out       = wbuf[ptr];
                     a.clear_si       = 1'b1;
                     ptr++;
                     remain--;
                  end
               end
               ST_RADDR_ACK: begin
                  a.start_action = CTL_CLEAR;
                  a.ack_action   = (remain > 1) ? CTL_SET : CTL_CLEAR;
                  a.clear_si     = 1'b1;
               end
               ST_RX_ACK: begin
                  a.rx_valid = 1'b1;
                  a.rx_index = ptr;
                  a.rx_byte  = r.bus_data_in;
                  ptr++;
                  if (remain != 0) remain--;
                  // NACK the last byte
                  a.ack_action = (remain == 1) ? CTL_CLEAR : CTL_SET;
                  a.clear_si   = 1'b1;
               end
               ST_RX_NACK: begin
                  a.rx_valid = 1'b1;
                  a.rx_index = ptr;
                  a.rx_byte  = r.bus_data_in;
                  a = stop_and_finish(a);
               end
               ST_ARB_LOST: begin
                  // bus is gone: no STOP, leave SI alone
                  a.done_res     = tgt[0] ? DONE_READ : DONE_WRITE;
                  a.error_flag   = 1'b1;
                  a.error_status = r.status_code;
               end
               default: begin
                  a.error_flag   = 1'b1;
                  a.error_status = r.status_code;
                  a = stop_and_finish(a);
               end
            endcase
         end
         default: ;
      endcase
      return a;
   endfunction

   task automatic check_field(input string fname, input logic [7:0] exp_val,
                              input logic [7:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t ns  %s mismatch: expected 0x%0h, actual 0x%0h",
                  $time, fname, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tgt       = '0;
         reg_idx   = '0;
         remain    = '0;
         ptr       = '0;
         expected_actions.delete();
         pending   = 0;
      end else begin
         if (req_valid && !req_stall) expected_actions.push_back(next_actions(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_actions.size() == 0) begin
               $display("%0t ns  unexpected action set 0x%0h", $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_actions.pop_front();
               check_field("data_out_valid", want.data_out_valid, rsp_data.data_out_valid);
               check_field("data_out", want.data_out, rsp_data.data_out);
               check_field("start_action", want.start_action, rsp_data.start_action);
               check_field("stop_set", want.stop_set, rsp_data.stop_set);
               check_field("ack_action", want.ack_action, rsp_data.ack_action);
               check_field("clear_si", want.clear_si, rsp_data.clear_si);
               check_field("rx_valid", want.rx_valid, rsp_data.rx_valid);
               check_field("rx_index", want.rx_index, rsp_data.rx_index);
               check_field("rx_byte", want.rx_byte, rsp_data.rx_byte);
               check_field("done_res", want.done_res, rsp_data.done_res);
               check_field("error_flag", want.error_flag, rsp_data.error_flag);
               check_field("error_status", want.error_status, rsp_data.error_status);
               checked_count++;
               if (want.done_res != DONE_BUSY) done_count++;
            end
         end
         pending = expected_actions.size();
      end
   end

endmodule

### sim/tb_i2c_master_register_transfer_fsm_unit.sv
// Testbench top for the I2C master register transfer unit: stimulus, stall pattern and verdict.
`timescale 1ns / 100ps
module tb_i2c_master_register_transfer_fsm_unit;
   import i2cm_pkg::*;

   localparam int N_ITEMS        = 1300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int QUIET_CYCLES   = 20;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Status codes the unit treats as errors
   localparam logic [7:0] ST_BUS_ERR    = 8'h00;
   localparam logic [7:0] ST_ADDR_NACK  = 8'h20;
   localparam logic [7:0] ST_DATA_NACK  = 8'h30;
   localparam logic [7:0] ST_RADDR_NACK = 8'h48;
   localparam logic [7:0] ST_SLAVE_RX   = 8'h60;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int checked_count;
   int done_count;
   int send_idle_pct;
   int recv_stall_pct;
   int items;
   int transfers;
   int idle_cycles;

   // Just enough of the transfer state to keep write data pointing at loaded entries
   bit               sh_read;
   logic [LEN_W-1:0] sh_remain;
   logic [7:0]       sh_ptr;
   bit               written [BUF_DEPTH];

   i2c_master_register_transfer_fsm_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   i2c_master_register_transfer_fsm_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count),
      .done_count    (done_count)
   );

   always #4 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns  no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type random_request();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic req_type transfer_start(input logic [7:0] tgt, input logic [7:0] reg_index,
                                              input logic [LEN_W-1:0] len);
      req_type r;
      r                = random_request();
      r.op             = OP_START;
      r.target_byte    = tgt;
      r.first_register = reg_index;
      r.length         = len;
      return r;
   endfunction

   function automatic req_type buffer_load(input logic [7:0] idx, input logic [7:0] data);
      req_type r;
      r            = random_request();
      r.op         = OP_LOAD;
      r.load_index = idx;
      r.load_data  = data;
      return r;
   endfunction

   function automatic req_type status_event(input logic [7:0] code);
      req_type r;
      r             = random_request();
      r.op          = OP_EVENT;
      r.status_code = code;
      return r;
   endfunction

   function automatic logic [7:0] protocol_status();
      case ($urandom_range(6))
         0:       return ST_START;
         1:       return ST_RESTART;
         2:       return ST_ADDR_ACK;
         3:       return ST_DATA_ACK;
         4:       return ST_RADDR_ACK;
         5:       return ST_RX_ACK;
         default: return ST_RX_NACK;
      endcase
   endfunction

   function automatic logic [7:0] fault_status();
      case ($urandom_range(6))
         0:       return ST_BUS_ERR;
         1:       return ST_ADDR_NACK;
         2:       return ST_DATA_NACK;
         3:       return ST_RADDR_NACK;
         4:       return ST_ARB_LOST;
         5:       return ST_SLAVE_RX;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic drive_item(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      case (r.op)
         OP_START: begin
            sh_read   = r.target_byte[0];
            sh_remain = (r.length > LEN_CAP) ? LEN_CAP : r.length;
            sh_ptr    = '0;
         end
         OP_LOAD: written[r.load_index] = 1'b1;
         OP_EVENT: begin
            if (r.status_code == ST_DATA_ACK && !sh_read && sh_remain != 0) begin
               sh_ptr++;
               sh_remain--;
            end else if (r.status_code == ST_RX_ACK) begin
               sh_ptr++;
               if (sh_remain != 0) sh_remain--;
            end
         end
         default: ;
      endcase
      if (r.op != OP_UNUSED) items++;
   endtask

   // Load the next write byte first if the transfer would send an entry never written
   task automatic send_request(input req_type r);
      if (r.op == OP_EVENT && r.status_code == ST_DATA_ACK && !sh_read && sh_remain != 0
          && !written[sh_ptr]) begin
         drive_item(buffer_load(sh_ptr, 8'($urandom)));
      end
      drive_item(r);
   endtask

   task automatic wait_for_actions();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic run_register_transfer();
      logic [7:0]       tgt;
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] n;
      logic [7:0]       codes[$];
      int unsigned      p;
      int unsigned      fault_at;
      int unsigned      k;
      tgt = 8'($urandom);
      p   = $urandom_range(99);
      if (p < 55)      len = LEN_W'($urandom_range(4));
      else if (p < 85) len = LEN_W'($urandom_range(16, 5));
      else if (p < 99) len = LEN_W'($urandom_range(60, 17));
      else             len = LEN_W'($urandom_range(511));
      n = (len > LEN_CAP) ? LEN_CAP : len;
      send_request(transfer_start(tgt, 8'($urandom), len));
      if (!tgt[0] && n <= 40) begin
         for (k = 0; k < n; k++) send_request(buffer_load(8'(k), 8'($urandom)));
      end
      codes = {ST_START, ST_ADDR_ACK};
      if (n != 0) begin
         if (tgt[0]) begin
            codes.push_back(ST_DATA_ACK);
            codes.push_back(ST_RESTART);
            codes.push_back(ST_RADDR_ACK);
            repeat (n - 1) codes.push_back(ST_RX_ACK);
            codes.push_back(ST_RX_NACK);
         end else begin
            repeat (n + 1) codes.push_back(ST_DATA_ACK);
         end
      end
      // break off some transfers on an error status
      if ($urandom_range(99) < 20) begin
         fault_at        = $urandom_range(codes.size() - 1);
         codes[fault_at] = fault_status();
         codes           = codes[0:fault_at];
      end
      if ($urandom_range(99) < 10) codes.push_back(8'($urandom));
      foreach (codes[i]) send_request(status_event(codes[i]));
      transfers++;
   endtask

   initial begin
      req_type r;
      int      phase;
      int      pick;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      send_idle_pct  = 28;
      recv_stall_pct = 86;
      phase          = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // unused op with every bit set
      drive_item('1);
      drive_item(buffer_load(8'h00, 8'hFF));
      drive_item(buffer_load(8'hFF, 8'h00));

      // one-byte write to the top write address
      send_request(transfer_start(8'hFE, 8'hFF, 9'd1));
      send_request(status_event(ST_START));
      send_request(status_event(ST_ADDR_ACK));
      send_request(status_event(ST_DATA_ACK));
      send_request(status_event(ST_DATA_ACK));

      // one-byte read: repeated START, then NACK on the only byte
      send_request(transfer_start(8'hFF, 8'h00, 9'd1));
      send_request(status_event(ST_START));
      send_request(status_event(ST_ADDR_ACK));
      send_request(status_event(ST_DATA_ACK));
      send_request(status_event(ST_RESTART));
      send_request(status_event(ST_RADDR_ACK));
      r             = status_event(ST_RX_NACK);
      r.bus_data_in = 8'hFF;
      send_request(r);

      // oversized length saturates; arbitration loss mid-read
      send_request(transfer_start(8'h01, 8'hA5, 9'h1FF));
      send_request(status_event(ST_START));
      send_request(status_event(ST_RX_ACK));
      send_request(status_event(ST_ARB_LOST));

      // zero length probes the address only
      send_request(transfer_start(8'h00, 8'h5A, 9'd0));
      send_request(status_event(ST_START));
      send_request(status_event(ST_ADDR_ACK));

      send_request(status_event(ST_BUS_ERR));
      send_request(status_event(ST_SLAVE_RX));
      // received byte with nothing left to read
      r             = status_event(ST_RX_ACK);
      r.bus_data_in = 8'h00;
      send_request(r);

      while (items < N_ITEMS) begin
         if (phase == 0 && items >= N_ITEMS / 3) begin
            wait_for_actions();
            send_idle_pct  = 86;
            recv_stall_pct = 28;
            phase          = 1;
         end else if (phase == 1 && items >= 2 * N_ITEMS / 3) begin
            wait_for_actions();
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            phase          = 2;
         end
         pick = $urandom_range(99);
         if (pick < 80) begin
            run_register_transfer();
         end else if (pick < 90) begin
            send_request(random_request());
         end else begin
            repeat ($urandom_range(6, 1)) send_request(status_event(protocol_status()));
         end
      end

      wait_for_actions();
      repeat (QUIET_CYCLES) @(negedge clock);
      $display("Sent %0d items in %0d register transfers plus noise and stray status events",
               items, transfers);
      $display("Checked %0d action sets, %0d of them ending a transfer", checked_count,
               done_count);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
